@@ src/phtb_pkg.sv @@
// Shared types, constants and register codes for the per-host token bucket table.
package phtb_pkg;

  localparam int HostsPerTable = 254;
  localparam int Networks      = 255;
  localparam int HostAw        = 8;
  localparam int NetAw         = 8;
  localparam int C3Aw          = NetAw + HostAw;

  typedef enum logic [2:0] {
    REG_HOST2_RATE = 3'd0,
    REG_HOST2_MAX  = 3'd1,
    REG_NET3_RATE  = 3'd2,
    REG_NET3_MAX   = 3'd3,
    REG_HOST3_RATE = 3'd4,
    REG_HOST3_MAX  = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_C2_RD,
    ST_C2_CMP,
    ST_N3_RD,
    ST_N3_CMP,
    ST_H3_RD,
    ST_H3_CMP,
    ST_T2_RD,
    ST_T2_WR,
    ST_TN_RD,
    ST_TN_WR,
    ST_TH_CNT,
    ST_TH_RD,
    ST_TH_WR,
    ST_OUT
  } state_t;

  // Table selector for the datapath's shared read and refill unit.
  typedef enum logic [1:0] {
    TBL_C2 = 2'd0,
    TBL_N3 = 2'd1,
    TBL_H3 = 2'd2
  } tbl_t;

  typedef struct packed {
    logic       clr_idx;
    logic       inc_idx;
    logic       rd_en;
    tbl_t       tbl;
    logic       append;
    logic       refill_wr;
    logic       set_net;
    logic       set_res;
    logic [1:0] res_class;
    logic       res_full;
    logic       res_use_pos;
    logic       next_net;
  } ctl_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic       full;
    logic       net_done;
  } sts_t;

  function automatic logic signed [31:0] refill_calc(
    input logic signed [31:0] b,
    input logic signed [24:0] rate,
    input logic        [30:0] mx,
    input logic signed [40:0] prod
  );
    logic signed [42:0] s;
    begin
      s = 43'(b) + 43'(prod);
      if (b == $signed({1'b0, mx})) refill_calc = b;
      else if (s > $signed({12'd0, mx})) refill_calc = $signed({1'b0, mx});
      else if (s < -43'sd2147483648) refill_calc = 32'sh8000_0000;
      else refill_calc = s[31:0];
      if (rate == -25'sd1) refill_calc = b;
    end
  endfunction

endpackage

@@ src/phtb_ctrl.sv @@
// Sequencer for classify lookups and refill sweeps of the bucket tables.
module phtb_ctrl
  import phtb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       op,
  input  logic [1:0] cls,
  input  logic       bad,
  input  logic       zero_secs,
  input  logic       out_taken,
  input  sts_t       sts,
  output ctl_t       ctl,
  output logic       busy,
  output logic       res_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (op) state_nxt = zero_secs ? ST_OUT : ST_T2_RD;
        else if (cls == 2'd2 && !bad) state_nxt = ST_C2_RD;
        else if (cls == 2'd3 && !bad) state_nxt = ST_N3_RD;
        else state_nxt = ST_OUT;
      end
      ST_C2_RD:  state_nxt = ST_C2_CMP;
      ST_C2_CMP: if (sts.hit || sts.done) state_nxt = ST_OUT;
                 else state_nxt = ST_C2_RD;
      ST_N3_RD:  state_nxt = ST_N3_CMP;
      ST_N3_CMP: begin
        if (sts.hit || (sts.done && !sts.full)) state_nxt = ST_H3_RD;
        else if (sts.done) state_nxt = ST_OUT;
        else state_nxt = ST_N3_RD;
      end
      ST_H3_RD:  state_nxt = ST_H3_CMP;
      ST_H3_CMP: if (sts.hit || sts.done) state_nxt = ST_OUT;
                 else state_nxt = ST_H3_RD;
      ST_T2_RD:  state_nxt = sts.done ? ST_TN_RD : ST_T2_WR;
      ST_T2_WR:  state_nxt = ST_T2_RD;
      ST_TN_RD:  state_nxt = sts.net_done ? ST_OUT : ST_TN_WR;
      ST_TN_WR:  state_nxt = ST_TH_CNT;
      ST_TH_CNT: state_nxt = ST_TH_RD;
      ST_TH_RD:  state_nxt = sts.done ? ST_TN_RD : ST_TH_WR;
      ST_TH_WR:  state_nxt = ST_TH_RD;
      ST_OUT:    if (out_taken) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: ;
      ST_DECIDE: begin
        ctl.clr_idx = 1'b1;
        ctl.set_res = 1'b1;
        ctl.res_class = (!op && cls == 2'd1) ? 2'd1 : 2'd0;
      end
      ST_C2_RD: begin ctl.rd_en = 1'b1; ctl.tbl = TBL_C2; end
      ST_C2_CMP: begin
        ctl.tbl = TBL_C2;
        ctl.inc_idx = 1'b1;
        if (sts.hit || sts.done) begin
          ctl.set_res = 1'b1;
          ctl.res_full = !sts.hit && sts.full;
          ctl.res_class = ctl.res_full ? 2'd0 : 2'd2;
          ctl.res_use_pos = !ctl.res_full;
          ctl.append = !sts.hit && !sts.full;
        end
      end
      ST_N3_RD: begin ctl.rd_en = 1'b1; ctl.tbl = TBL_N3; end
      ST_N3_CMP: begin
        ctl.tbl = TBL_N3;
        ctl.inc_idx = 1'b1;
        if (sts.hit || sts.done) begin
          ctl.append = !sts.hit && !sts.full;
          ctl.set_net = sts.hit || !sts.full;
          ctl.clr_idx = ctl.set_net;
          ctl.set_res = !ctl.set_net;
          ctl.res_full = 1'b1;
        end
      end
      ST_H3_RD: begin ctl.rd_en = 1'b1; ctl.tbl = TBL_H3; end
      ST_H3_CMP: begin
        ctl.tbl = TBL_H3;
        ctl.inc_idx = 1'b1;
        if (sts.hit || sts.done) begin
          ctl.set_res = 1'b1;
          ctl.res_full = !sts.hit && sts.full;
          ctl.res_class = ctl.res_full ? 2'd0 : 2'd3;
          ctl.res_use_pos = !ctl.res_full;
          ctl.append = !sts.hit && !sts.full;
        end
      end
      ST_T2_RD: begin
        ctl.rd_en = 1'b1; ctl.tbl = TBL_C2;
        ctl.clr_idx = sts.done;
      end
      ST_T2_WR: begin ctl.tbl = TBL_C2; ctl.refill_wr = 1'b1; ctl.inc_idx = 1'b1; end
      ST_TN_RD: begin ctl.rd_en = 1'b1; ctl.tbl = TBL_N3; end
      ST_TN_WR: begin ctl.tbl = TBL_N3; ctl.refill_wr = 1'b1; ctl.set_net = 1'b1; end
      ST_TH_CNT: begin ctl.tbl = TBL_H3; ctl.clr_idx = 1'b1; end
      ST_TH_RD: begin
        ctl.rd_en = 1'b1; ctl.tbl = TBL_H3;
        ctl.next_net = sts.done;
        ctl.clr_idx = sts.done;
      end
      ST_TH_WR: begin ctl.tbl = TBL_H3; ctl.refill_wr = 1'b1; ctl.inc_idx = 1'b1; end
      ST_OUT: ;
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_OUT);

endmodule

@@ src/phtb_dp.sv @@
// Bucket tables, lookup compare, refill arithmetic and result register.
module phtb_dp
  import phtb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [7:0]         net_in,
  input  logic [7:0]         host_in,
  input  logic [15:0]        secs_in,
  input  logic signed [24:0] host2_rate,
  input  logic [30:0]        host2_max,
  input  logic signed [24:0] net3_rate,
  input  logic [30:0]        net3_max,
  input  logic signed [24:0] host3_rate,
  input  logic [30:0]        host3_max,
  input  ctl_t               ctl,
  output sts_t               sts,
  output logic [1:0]         pool_class,
  output logic [15:0]        bucket_position,
  output logic               accepted,
  output logic               table_full
);

  logic [7:0]  c2_key  [HostsPerTable];
  logic [31:0] c2_bkt  [HostsPerTable];
  logic [7:0]  n3_key  [Networks];
  logic [31:0] n3_bkt  [Networks];
  logic [7:0]  h3_cnt  [Networks];
  logic [39:0] h3_mem  [2**C3Aw];

  logic [7:0]  c2_cnt_r, n3_cnt_r, hcnt_r;
  logic [8:0]  idx_r;
  logic [7:0]  net_r, host_r, nsel_r, tnet_r;
  logic [15:0] secs_r;
  logic [7:0]  key_r;
  logic [31:0] bkt_r;
  logic signed [40:0] prod_r;
  logic        valid_rd_r;
  logic [1:0]  pc_r;
  logic [15:0] pos_r;
  logic        full_r;

  logic [7:0]  cnt_cur;
  logic [8:0]  cap;
  logic [7:0]  key_cmp;
  logic signed [24:0] rate_cur;
  logic [30:0] max_cur;
  logic [15:0] h3_addr;

  always_comb begin
    cnt_cur = c2_cnt_r; cap = 9'(HostsPerTable); key_cmp = host_r;
    rate_cur = host2_rate; max_cur = host2_max;
    case (ctl.tbl)
      TBL_N3: begin
        cnt_cur = n3_cnt_r; cap = 9'(Networks); key_cmp = net_r;
        rate_cur = net3_rate; max_cur = net3_max;
      end
      TBL_H3: begin
        cnt_cur = hcnt_r; rate_cur = host3_rate; max_cur = host3_max;
      end
      default: ;
    endcase
  end

  assign sts.done = idx_r >= {1'b0, cnt_cur};
  assign sts.full = {1'b0, cnt_cur} >= cap;
  assign sts.hit = valid_rd_r && !sts.done && key_r == key_cmp;
  assign sts.net_done = {1'b0, tnet_r} >= {1'b0, n3_cnt_r};
  assign h3_addr = {nsel_r, idx_r[7:0]};

  always_ff @(posedge clk) begin
    if (ctl.rd_en && !sts.done) begin
      case (ctl.tbl)
        TBL_C2: begin key_r <= c2_key[idx_r[7:0]]; bkt_r <= c2_bkt[idx_r[7:0]]; end
        TBL_N3: begin key_r <= n3_key[idx_r[7:0]]; bkt_r <= n3_bkt[tnet_r]; end
        default: begin key_r <= h3_mem[h3_addr][39:32]; bkt_r <= h3_mem[h3_addr][31:0]; end
      endcase
    end
    prod_r <= rate_cur * $signed({1'b0, secs_r});
    if (ctl.append) begin
      case (ctl.tbl)
        TBL_C2: begin c2_key[c2_cnt_r] <= host_r; c2_bkt[c2_cnt_r] <= 32'(host2_rate); end
        TBL_N3: begin n3_key[n3_cnt_r] <= net_r; n3_bkt[n3_cnt_r] <= 32'(net3_rate); end
        default: begin
          h3_mem[{nsel_r, hcnt_r}] <= {host_r, 32'(host3_rate)};
          h3_cnt[nsel_r] <= hcnt_r + 8'd1;
        end
      endcase
    end
    if (ctl.set_net && !ctl.refill_wr && !sts.hit) h3_cnt[n3_cnt_r] <= 8'd0;
    if (ctl.refill_wr) begin
      case (ctl.tbl)
        TBL_C2: c2_bkt[idx_r[7:0]] <=
          refill_calc($signed(bkt_r), rate_cur, max_cur, prod_r);
        TBL_N3: n3_bkt[tnet_r] <= refill_calc($signed(bkt_r), rate_cur, max_cur, prod_r);
        default: h3_mem[h3_addr] <=
          {key_r, refill_calc($signed(bkt_r), rate_cur, max_cur, prod_r)};
      endcase
    end
    if (load) begin
      net_r <= net_in; host_r <= host_in; secs_r <= secs_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_cnt_r <= '0; n3_cnt_r <= '0; hcnt_r <= '0; idx_r <= '0;
      nsel_r <= '0; tnet_r <= '0; valid_rd_r <= 1'b0;
      pc_r <= '0; pos_r <= '0; full_r <= 1'b0;
    end else begin
      valid_rd_r <= ctl.rd_en && !(ctl.refill_wr);
      if (load) tnet_r <= '0;
      if (ctl.clr_idx) idx_r <= '0;
      else if (ctl.inc_idx) idx_r <= idx_r + 9'd1;
      if (ctl.append) begin
        case (ctl.tbl)
          TBL_C2: c2_cnt_r <= c2_cnt_r + 8'd1;
          TBL_N3: n3_cnt_r <= n3_cnt_r + 8'd1;
          default: ;
        endcase
      end
      if (ctl.set_net && !ctl.refill_wr) begin
        nsel_r <= sts.hit ? 8'(idx_r) : n3_cnt_r;
        hcnt_r <= sts.hit ? h3_cnt[idx_r[7:0]] : 8'd0;
      end
      if (ctl.set_net && ctl.refill_wr) begin
        nsel_r <= tnet_r;
        hcnt_r <= (host3_rate == -25'sd1) ? 8'd0 : h3_cnt[tnet_r];
      end
      if (ctl.next_net) tnet_r <= tnet_r + 8'd1;
      if (ctl.set_res) begin
        pc_r <= ctl.res_class;
        full_r <= ctl.res_full;
        pos_r <= ctl.res_use_pos ?
          ((ctl.tbl == TBL_H3) ? {nsel_r, idx_r[7:0]} : {8'd0, idx_r[7:0]}) : 16'd0;
      end
    end
  end

  assign pool_class = pc_r;
  assign bucket_position = pos_r;
  assign accepted = (pc_r != 2'd0);
  assign table_full = full_r;

endmodule

@@ src/per_host_token_bucket_table_unit.sv @@
// Top level of the per-host token bucket table with its register file.
//
// Usage: one item enters on the in_ channel; one result beat leaves on out_.
// Unpooled, class 1, rejected items and zero-second ticks pass from the decide
// state straight to the output state. A class 2 or class 3 lookup searches
// linearly, reading and comparing each entry in turn until a hit or the one
// past the last entry. A tick walks every class 2 bucket, every class 3 network
// bucket and, unless the class 3 host rate is -1, every class 3 host bucket
// through one shared multiply and refill unit. One item is in flight at a time;
// in_stall is high from the cycle after acceptance until its result beat is
// taken, and the next item can be accepted once the controller is back in
// idle. The result is held in a register while out_stall is high. Reset
// clears the counts and the registers (rates -1, maxima 0); table contents
// are written before they are read and need no clearing pass.
// Registers are to be written through the cfg_ port only while the block is
// idle; the block itself does not enforce it.
module per_host_token_bucket_table_unit
  import phtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [1:0]  in_matched_class,
  input  logic [7:0]  in_net_byte,
  input  logic [7:0]  in_host_byte,
  input  logic [15:0] in_elapsed_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_pool_class,
  output logic [15:0] out_bucket_position,
  output logic        out_accepted,
  output logic        out_table_full,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic signed [24:0] host2_rate_r, net3_rate_r, host3_rate_r;
  logic [30:0] host2_max_r, net3_max_r, host3_max_r;
  logic        op_r, bad_r, zero_r, busy, start, out_taken, res_valid;
  logic [1:0]  cls_r;
  ctl_t        ctl;
  sts_t        sts;
  reg_idx_t    ridx;

  assign cfg_pready = 1'b1;
  assign ridx = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host2_rate_r <= -25'sd1; net3_rate_r <= -25'sd1; host3_rate_r <= -25'sd1;
      host2_max_r <= '0; net3_max_r <= '0; host3_max_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        REG_HOST2_RATE: host2_rate_r <= cfg_pwdata[24:0];
        REG_HOST2_MAX:  host2_max_r  <= cfg_pwdata[30:0];
        REG_NET3_RATE:  net3_rate_r  <= cfg_pwdata[24:0];
        REG_NET3_MAX:   net3_max_r   <= cfg_pwdata[30:0];
        REG_HOST3_RATE: host3_rate_r <= cfg_pwdata[24:0];
        REG_HOST3_MAX:  host3_max_r  <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_HOST2_RATE: cfg_prdata = 32'(host2_rate_r);
      REG_HOST2_MAX:  cfg_prdata = {1'b0, host2_max_r};
      REG_NET3_RATE:  cfg_prdata = 32'(net3_rate_r);
      REG_NET3_MAX:   cfg_prdata = {1'b0, net3_max_r};
      REG_HOST3_RATE: cfg_prdata = 32'(host3_rate_r);
      REG_HOST3_MAX:  cfg_prdata = {1'b0, host3_max_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign in_stall = busy;
  assign start = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= in_op;
      cls_r <= in_matched_class;
      zero_r <= (in_elapsed_seconds == 16'd0);
      bad_r <= (in_host_byte == 8'd0) || (in_host_byte == 8'hff) ||
               (in_matched_class == 2'd3 && in_net_byte == 8'hff);
    end
  end

  phtb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(op_r), .cls(cls_r),
    .bad(bad_r), .zero_secs(zero_r), .out_taken(out_taken), .sts(sts),
    .ctl(ctl), .busy(busy), .res_valid(res_valid)
  );

  phtb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .load(start), .net_in(in_net_byte),
    .host_in(in_host_byte), .secs_in(in_elapsed_seconds),
    .host2_rate(host2_rate_r), .host2_max(host2_max_r),
    .net3_rate(net3_rate_r), .net3_max(net3_max_r),
    .host3_rate(host3_rate_r), .host3_max(host3_max_r),
    .ctl(ctl), .sts(sts), .pool_class(out_pool_class),
    .bucket_position(out_bucket_position), .accepted(out_accepted),
    .table_full(out_table_full)
  );

  assign out_valid = res_valid;
  assign out_taken = out_valid && !out_stall;

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) busy |-> !start;
  endproperty
  assert property (p_no_accept_busy) else $error("item accepted while busy");

  property p_full_not_accepted;
    @(posedge clk) disable iff (!rst_n) out_valid && out_table_full |-> !out_accepted;
  endproperty
  assert property (p_full_not_accepted) else $error("full result marked accepted");

  property p_idle_after_take;
    @(posedge clk) disable iff (!rst_n) out_taken |=> !out_valid;
  endproperty
  assert property (p_idle_after_take) else $error("result repeated");

endmodule
